// File: design/mlfd_pkg.sv
`timescale 1ns / 1ps

package mlfd_pkg;

   // Frame geometry
   localparam int HEADER_BYTES    = 8;
   localparam int CHECK_BYTES     = 2;
   localparam int MAX_FRAME_BYTES = 1024;

   // Sync pair and header offsets
   localparam logic [7:0] SYNC_HI     = 8'hAA;
   localparam logic [7:0] SYNC_LO     = 8'h55;
   localparam int         POS_VERSION = 2;
   localparam int         POS_LENGTH  = 6;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 10;
   localparam int FLEN_W    = 11;
   localparam int MAXPAY_W  = 10;
   localparam int COUNT_W   = $clog2(MAX_FRAME_BYTES + 1);
   localparam int PAYLOAD_W = 16;
   localparam int TOTAL_W   = PAYLOAD_W + 1;

   // Register indexes on the csr port
   localparam logic CSR_EXPECTED_VERSION = 1'b0;
   localparam logic CSR_MAX_PAYLOAD      = 1'b1;

   typedef enum logic [1:0] {
      PH_WAIT1  = 2'd0,
      PH_WAIT2  = 2'd1,
      PH_HEADER = 2'd2,
      PH_REST   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_COMPLETE = 2'd1,
      EV_ERROR    = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_VERSION = 2'd1,
      ERR_LENGTH  = 2'd2
   } error_type;

   typedef struct packed {
      logic [1:0]         event_res;
      logic [1:0]         error_kind;
      logic               store_valid;
      logic [INDEX_W-1:0] store_index;
      logic [BYTE_W-1:0]  store_byte;
      logic [FLEN_W-1:0]  frame_length;
      logic [1:0]         kept_magic;
   } result_type;

endpackage

// File: design/magic_length_frame_deframer.sv
`timescale 1ns / 1ps

// Sync-word / length-field deframer.
// req_ channel: one raw byte per beat (req_rx_byte) with valid/ready.
// rsp_ channel: one result beat per input byte: event, error kind, the
//   kept frame byte with its position, frame length on completion, and the
//   count of sync bytes already reused as a new frame start after an error.
// csr_ port: write enable, index and data; index 0 is the expected version,
//   index 1 the largest payload. Write only while no byte is in flight.
// Throughput: one byte per cycle while the receiver takes results. A byte
//   is held in the input register, where the parser decodes it against the
//   frame state, and the result is then loaded into the output register,
//   which drives rsp_valid.
// Stall: when rsp_ready is low the output register holds; the input
//   register still takes one more byte, after which req_ready drops until
//   the result beat leaves.
// Reset: both registers empty, the parser hunts for the sync pair, and the
//   csr registers return to version 1 and a payload limit of 1014 bytes.
module magic_length_frame_deframer import mlfd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_event_res,
   output logic [1:0]          rsp_error_kind,
   output logic                rsp_store_valid,
   output logic [INDEX_W-1:0]  rsp_store_index,
   output logic [BYTE_W-1:0]   rsp_store_byte,
   output logic [FLEN_W-1:0]   rsp_frame_length,
   output logic [1:0]          rsp_kept_magic,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [MAXPAY_W-1:0] csr_write_data
);

   logic                in_valid_ff;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic                out_valid_ff;
   result_type          out_ff;
   result_type          result;
   logic                advance;
   logic [BYTE_W-1:0]   exp_version_ff;
   logic [MAXPAY_W-1:0] payload_limit_ff;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_version_ff   <= BYTE_W'(1);
         payload_limit_ff <= MAXPAY_W'(1014);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EXPECTED_VERSION: exp_version_ff   <= csr_write_data[BYTE_W-1:0];
            CSR_MAX_PAYLOAD:      payload_limit_ff <= csr_write_data;
            default:              ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   mlfd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .rx_byte          (in_byte_ff),
      .expected_version (exp_version_ff),
      .payload_limit    (payload_limit_ff),
      .result           (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_res    = out_ff.event_res;
   assign rsp_error_kind   = out_ff.error_kind;
   assign rsp_store_valid  = out_ff.store_valid;
   assign rsp_store_index  = out_ff.store_index;
   assign rsp_store_byte   = out_ff.store_byte;
   assign rsp_frame_length = out_ff.frame_length;
   assign rsp_kept_magic   = out_ff.kept_magic;

   // A header error always names its kind and keeps the last header byte
   a_error_kind : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_ERROR) |->
         (rsp_error_kind != ERR_NONE && rsp_store_valid))
      else $error("header error without kind or stored byte");

   // Kept sync bytes are reported only with a header error
   a_kept_magic : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kept_magic != 2'd0) |-> (rsp_event_res == EV_ERROR))
      else $error("kept_magic outside a header error");

   // A completed frame is at least a header long and ends at its last index
   a_complete_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_COMPLETE) |->
         (rsp_frame_length >= FLEN_W'(HEADER_BYTES) &&
          rsp_frame_length == FLEN_W'(rsp_store_index) + FLEN_W'(1)))
      else $error("completed frame length inconsistent");

   // A held result stays put while the receiver stalls
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_ff)))
      else $error("result changed under stall");

endmodule

// File: design/mlfd_parser.sv
`timescale 1ns / 1ps

module mlfd_parser import mlfd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [BYTE_W-1:0]   rx_byte,
   input  logic [BYTE_W-1:0]   expected_version,
   input  logic [MAXPAY_W-1:0] payload_limit,
   output result_type          result
);

   localparam logic [COUNT_W-1:0] HEADER_COUNT = COUNT_W'(HEADER_BYTES);
   localparam logic [COUNT_W-1:0] VERSION_POS  = COUNT_W'(POS_VERSION);
   localparam logic [COUNT_W-1:0] LEN_HI_POS   = COUNT_W'(POS_LENGTH);
   localparam logic [COUNT_W-1:0] LEN_LO_POS   = COUNT_W'(POS_LENGTH + 1);
   localparam logic [TOTAL_W-1:0] OVERHEAD     = TOTAL_W'(HEADER_BYTES + CHECK_BYTES);
   localparam logic [TOTAL_W-1:0] FRAME_LIMIT  = TOTAL_W'(MAX_FRAME_BYTES);

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] target_ff, target_in;
   logic [BYTE_W-1:0]  version_ff, version_in;
   logic [BYTE_W-1:0]  len_hi_ff, len_hi_in;
   logic [BYTE_W-1:0]  prev_ff, prev_in;

   // Shared decode of the current byte against the state
   logic [COUNT_W-1:0]   count_inc;
   logic [BYTE_W-1:0]    version_cur;
   logic [BYTE_W-1:0]    len_hi_cur;
   logic [BYTE_W-1:0]    len_lo_cur;
   logic [PAYLOAD_W-1:0] payload;
   logic [TOTAL_W-1:0]   total;
   logic                 hdr_last;
   logic                 ver_bad;
   logic                 len_bad;
   logic                 body_empty;
   logic                 tail_pair;
   logic                 tail_hi;
   logic                 rest_done;
   logic                 is_hi;
   logic                 is_lo;

   assign count_inc   = count_ff + COUNT_W'(1);
   assign is_hi       = (rx_byte == SYNC_HI);
   assign is_lo       = (rx_byte == SYNC_LO);
   assign version_cur = (count_ff == VERSION_POS) ? rx_byte : version_ff;
   assign len_hi_cur  = (count_ff == LEN_HI_POS)  ? rx_byte : len_hi_ff;
   assign len_lo_cur  = (count_ff == LEN_LO_POS)  ? rx_byte : target_ff[BYTE_W-1:0];
   assign payload     = {len_hi_cur, len_lo_cur};
   assign total       = OVERHEAD + TOTAL_W'(payload);
   assign hdr_last    = (count_inc >= HEADER_COUNT);
   assign ver_bad     = (version_cur != expected_version);
   assign len_bad     = (payload > PAYLOAD_W'(payload_limit)) || (total > FRAME_LIMIT);
   assign body_empty  = (total == TOTAL_W'(count_inc));
   assign tail_pair   = (prev_ff == SYNC_HI) && is_lo;
   assign tail_hi     = is_hi;
   assign rest_done   = (count_inc >= target_ff);

   // Next state
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      target_in  = target_ff;
      version_in = version_ff;
      len_hi_in  = len_hi_ff;
      prev_in    = prev_ff;
      unique case (phase_ff)
         PH_WAIT1: begin
            if (is_hi) begin
               phase_in = PH_WAIT2;
               count_in = COUNT_W'(1);
            end
         end
         PH_WAIT2: begin
            if (is_lo) begin
               phase_in = PH_HEADER;
               count_in = COUNT_W'(2);
            end else if (is_hi) begin
               count_in = COUNT_W'(1);
            end else begin
               phase_in = PH_WAIT1;
               count_in = '0;
            end
         end
         PH_HEADER: begin
            count_in   = count_inc;
            version_in = version_cur;
            len_hi_in  = len_hi_cur;
            target_in  = COUNT_W'(len_lo_cur);
            prev_in    = rx_byte;
            if (hdr_last) begin
               if (ver_bad || len_bad) begin
                  // rejected header: keep a trailing sync pair or sync byte
                  target_in = '0;
                  if (tail_pair) begin
                     phase_in = PH_HEADER;
                     count_in = COUNT_W'(2);
                  end else if (tail_hi) begin
                     phase_in = PH_WAIT2;
                     count_in = COUNT_W'(1);
                  end else begin
                     phase_in = PH_WAIT1;
                     count_in = '0;
                  end
               end else if (body_empty) begin
                  phase_in  = PH_WAIT1;
                  count_in  = '0;
                  target_in = '0;
               end else begin
                  phase_in  = PH_REST;
                  target_in = total[COUNT_W-1:0];
               end
            end
         end
         PH_REST: begin
            count_in = count_inc;
            if (rest_done) begin
               phase_in  = PH_WAIT1;
               count_in  = '0;
               target_in = '0;
            end
         end
         default: phase_in = PH_WAIT1;
      endcase
   end

   // Result for the current byte
   always_comb begin
      result = '0;
      unique case (phase_ff)
         PH_WAIT1: begin
            if (is_hi) begin
               result.store_valid = 1'b1;
               result.store_byte  = rx_byte;
            end
         end
         PH_WAIT2: begin
            if (is_lo || is_hi) begin
               result.store_valid = 1'b1;
               result.store_index = is_lo ? INDEX_W'(1) : '0;
               result.store_byte  = rx_byte;
            end
         end
         PH_HEADER: begin
            result.store_valid = 1'b1;
            result.store_index = count_ff[INDEX_W-1:0];
            result.store_byte  = rx_byte;
            if (hdr_last) begin
               if (ver_bad || len_bad) begin
                  result.event_res  = EV_ERROR;
                  result.error_kind = ver_bad ? ERR_VERSION : ERR_LENGTH;
                  result.kept_magic = tail_pair ? 2'd2 : (tail_hi ? 2'd1 : 2'd0);
               end else if (body_empty) begin
                  result.event_res    = EV_COMPLETE;
                  result.frame_length = total[FLEN_W-1:0];
               end
            end
         end
         PH_REST: begin
            result.store_valid = 1'b1;
            result.store_index = count_ff[INDEX_W-1:0];
            result.store_byte  = rx_byte;
            if (rest_done) begin
               result.event_res    = EV_COMPLETE;
               result.frame_length = FLEN_W'(count_inc);
            end
         end
         default: result = '0;
      endcase
   end

   // State registers, moved once per byte handed to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT1;
         count_ff   <= '0;
         target_ff  <= '0;
         version_ff <= '0;
         len_hi_ff  <= '0;
         prev_ff    <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         target_ff  <= target_in;
         version_ff <= version_in;
         len_hi_ff  <= len_hi_in;
         prev_ff    <= prev_in;
      end
   end

endmodule
